>>> src/ic2d_pkg.sv
package ic2d_pkg;

  // default build parameters
  localparam int MAX_KERNEL_DEF = 7;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;

  // field and register widths
  localparam int KIND_W  = 2;
  localparam int PIX_W   = 8;
  localparam int CIDX_W  = 6;
  localparam int COEF_W  = 16;
  localparam int IW_W    = 11;
  localparam int IH_W    = 13;
  localparam int KS_W    = 3;
  localparam int ROW_W   = 12;
  localparam int KCNT_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FRAC_W  = 12;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [PIX_W-1:0]         pixel_in;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

endpackage

>>> src/ic2d_stream_if.sv
interface ic2d_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/image_convolution_2d.sv
// channel   dir  payload                                  handshake
// in_ch     in   kind, pixel_in, coef_index, coef_value   valid/ready
// out_ch    out  pixel_out, frame_last                    valid/ready
// cfg       in   cfg_we, cfg_index, cfg_data              write only, no wait
//
// coefficient items and ignored items are taken while the sequencer is idle; a pixel or drain
// item goes through a readiness check and, when it yields an item, a run state
// (one pass of the shared multiply-accumulate over the taps, three stages deep)
// and a finish state that loads the output register
// in_ch.ready is low while an item is in work; a finished item sits in the output
// register, and the block stalls before loading the next one until out_ch takes it
// synchronous active-high reset clears positions and the frame flag and sets the
// configuration registers to their defaults; the line and coefficient memories are not cleared
module image_convolution_2d
  import ic2d_pkg::*;
#(
  parameter int MAX_KERNEL = MAX_KERNEL_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ic2d_stream_if.sink           in_ch,
  ic2d_stream_if.source         out_ch
);

  // derived sizes
  localparam int CW         = $clog2(MAX_WIDTH);          // column bits
  localparam int WW         = $clog2(MAX_WIDTH + 1);      // effective width bits
  localparam int SB         = $clog2(MAX_KERNEL + 1);     // row slot bits
  localparam int LINE_DEPTH = (2 ** SB) * (2 ** CW);
  localparam int LA         = SB + CW;
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int CA         = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int PROD_W     = COEF_W + PIX_W + 1;
  localparam int ACC_W      = PROD_W + CA + 1;
  localparam int RP_W       = ROW_W + 2;
  localparam int CP_W       = CW + 2;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state;

  // configuration registers
  logic [IW_W-1:0] image_width;
  logic [IH_W-1:0] image_height;
  logic [KS_W-1:0] kernel_width;
  logic [KS_W-1:0] kernel_height;

  // positions
  logic [CW-1:0]    in_col, out_col;
  logic [ROW_W-1:0] in_row, out_row;
  logic             in_full;

  // tap walk
  logic [KCNT_W-1:0]     ti, tj;
  logic [CA-1:0]         tap;
  logic                  issue_done;
  logic signed [RP_W-1:0] row_pos;
  logic signed [CP_W-1:0] col_pos;
  logic                  vld1, vld2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // output register
  logic      out_valid;
  out_item_t out_data;

  // effective geometry
  logic [WW-1:0]    w_eff;
  logic [CW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [KS_W-1:0]  rw, rh;
  logic             kernel_ok;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if ({{(WW + IW_W){1'b0}}, image_width} > (WW + IW_W + IW_W)'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    w_m1 = CW'(w_eff - WW'(1));
    if (image_height == '0) begin
      h_m1 = '0;
    end else if (image_height > IH_W'(MAX_HEIGHT)) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(image_height - IH_W'(1));
    end
    rw = kernel_width >> 1;
    rh = kernel_height >> 1;
    kernel_ok = kernel_width[0] && kernel_height[0] &&
                ({1'b0, kernel_width} <= KCNT_W'(MAX_KERNEL)) &&
                ({1'b0, kernel_height} <= KCNT_W'(MAX_KERNEL));
  end

  // input accept only while the sequencer waits
  logic    in_fire;
  in_item_t item;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign item        = in_ch.data;

  logic is_coef, is_work, takes_pixel;
  assign is_coef     = in_fire && (item.kind == KIND_COEF);
  assign is_work     = in_fire && kernel_ok &&
                       ((item.kind == KIND_PIXEL) || (item.kind == KIND_DRAIN));
  assign takes_pixel = is_work && (item.kind == KIND_PIXEL) && !in_full;

  // coefficient store
  logic                     coef_we;
  logic signed [COEF_W-1:0] coef_rd;
  assign coef_we = is_coef && ({2'b00, item.coef_index} < (CIDX_W + 2)'(COEF_DEPTH));

  ic2d_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH), .AW(CA)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CA'(item.coef_index)),
    .wdata (item.coef_value),
    .raddr (tap),
    .rdata (coef_rd)
  );

  // line store: row slot above column
  logic [ROW_W-1:0] r_clamp;
  logic [CW-1:0]    c_clamp;
  logic [PIX_W-1:0] line_rd;

  always_comb begin
    if (row_pos < 0) begin
      r_clamp = '0;
    end else if (row_pos > $signed({2'b00, h_m1})) begin
      r_clamp = h_m1;
    end else begin
      r_clamp = ROW_W'(row_pos);
    end
    if (col_pos < 0) begin
      c_clamp = '0;
    end else if (col_pos > $signed({2'b00, w_m1})) begin
      c_clamp = w_m1;
    end else begin
      c_clamp = CW'(col_pos);
    end
  end

  ic2d_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH), .AW(LA)) u_line_ram (
    .clk   (clk),
    .we    (takes_pixel),
    .waddr ({in_row[SB-1:0], in_col}),
    .wdata (item.pixel_in),
    .raddr ({r_clamp[SB-1:0], c_clamp}),
    .rdata (line_rd)
  );

  // output readiness: every source pixel of the window has arrived
  logic [ROW_W:0] nr_sum;
  logic [CW:0]    nc_sum;
  logic [ROW_W-1:0] nr;
  logic [CW-1:0]    nc;
  logic             out_ready_pos;

  always_comb begin
    nr_sum = {1'b0, out_row} + (ROW_W + 1)'(rh);
    nc_sum = {1'b0, out_col} + (CW + 1)'(rw);
    nr = (nr_sum > {1'b0, h_m1}) ? h_m1 : ROW_W'(nr_sum);
    nc = (nc_sum > {1'b0, w_m1}) ? w_m1 : CW'(nc_sum);
    out_ready_pos = in_full || (in_row > nr) || ((in_row == nr) && (in_col > nc));
  end

  // result formatting: floor then clip to 0..255
  logic [PIX_W-1:0] pix_res;
  logic             last_pos;
  always_comb begin
    if (acc <= 0) begin
      pix_res = '0;
    end else if (|acc[ACC_W-1:FRAC_W+PIX_W]) begin
      pix_res = '1;
    end else begin
      pix_res = acc[FRAC_W+PIX_W-1:FRAC_W];
    end
    last_pos = (out_row == h_m1) && (out_col == w_m1);
  end

  logic load_out;
  assign load_out = (state == S_FIN) && (!out_valid || out_ch.ready);

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  logic issuing, last_col, last_row;
  assign issuing  = (state == S_RUN) && !issue_done;
  assign last_col = (tj == KCNT_W'(kernel_width) - KCNT_W'(1));
  assign last_row = (ti == KCNT_W'(kernel_height) - KCNT_W'(1));

  // sequencer, positions and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= IW_W'(1024);
      image_height  <= IH_W'(1);
      kernel_width  <= KS_W'(3);
      kernel_height <= KS_W'(3);
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      in_full       <= 1'b0;
      issue_done    <= 1'b0;
      vld1          <= 1'b0;
      vld2          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      vld1 <= issuing;
      vld2 <= vld1;

      if (cfg_we && (cfg_index <= REG_KERNEL_HEIGHT)) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   image_width   <= cfg_data[IW_W-1:0];
          REG_IMAGE_HEIGHT:  image_height  <= cfg_data[IH_W-1:0];
          REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[KS_W-1:0];
          REG_KERNEL_HEIGHT: kernel_height <= cfg_data[KS_W-1:0];
          default: ;
        endcase
        // a register write restarts the frame
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        in_full <= 1'b0;
      end else begin
        case (state)
          S_IDLE: begin
            if (takes_pixel) begin
              if ({1'b0, in_col} >= (CW + 1)'(w_m1)) begin
                in_col <= '0;
                if (in_row >= h_m1) begin
                  in_row  <= '0;
                  in_full <= 1'b1;
                end else begin
                  in_row <= in_row + ROW_W'(1);
                end
              end else begin
                in_col <= in_col + CW'(1);
              end
            end
            if (is_work) begin
              state <= S_CHECK;
            end
          end
          S_CHECK: begin
            // set up the tap walk at the window's top-left corner
            ti         <= '0;
            tj         <= '0;
            tap        <= '0;
            issue_done <= 1'b0;
            row_pos    <= $signed({2'b00, out_row}) - $signed(RP_W'(rh));
            col_pos    <= $signed({2'b00, out_col}) - $signed(CP_W'(rw));
            state      <= out_ready_pos ? S_RUN : S_IDLE;
          end
          S_RUN: begin
            if (issuing) begin
              tap <= tap + CA'(1);
              if (last_col) begin
                tj      <= '0;
                col_pos <= $signed({2'b00, out_col}) - $signed(CP_W'(rw));
                row_pos <= row_pos + RP_W'(1);
                ti      <= ti + KCNT_W'(1);
                if (last_row) begin
                  issue_done <= 1'b1;
                end
              end else begin
                tj      <= tj + KCNT_W'(1);
                col_pos <= col_pos + CP_W'(1);
              end
            end else if (!vld1 && !vld2) begin
              state <= S_FIN;
            end
          end
          S_FIN: begin
            if (load_out) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
              if (last_pos) begin
                out_row <= '0;
                out_col <= '0;
                in_full <= 1'b0;
              end else if (out_col == w_m1) begin
                out_col <= '0;
                out_row <= out_row + ROW_W'(1);
              end else begin
                out_col <= out_col + CW'(1);
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // shared multiply-accumulate and output payload
  always_ff @(posedge clk) begin
    if (vld1) begin
      prod <= coef_rd * $signed({1'b0, line_rd});
    end
    // accumulator clears while the walk is set up
    if (state == S_CHECK) begin
      acc <= '0;
    end else if (vld2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (load_out) begin
      out_data.pixel_out  <= pix_res;
      out_data.frame_last <= last_pos;
    end
  end

  // a full frame always waits at the origin of the input raster
  assert property (@(posedge clk) disable iff (rst)
    in_full |-> (in_col == '0) && (in_row == '0))
    else $error("input position moved while frame full");

  // the tap walk stays inside the kernel
  assert property (@(posedge clk) disable iff (rst)
    issuing |-> (ti < KCNT_W'(kernel_height)) && (tj < KCNT_W'(kernel_width)))
    else $error("tap walk left the kernel");

  // an accepted pixel or drain item with a valid kernel starts the readiness check
  assert property (@(posedge clk) disable iff (rst)
    (is_work && !cfg_we) |=> (state == S_CHECK))
    else $error("work item did not start the sequencer");

endmodule

>>> src/ic2d_ram.sv
module ic2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/sv/testbench.sv
module testbench;
  import ic2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // long enough for the longest item, 49 taps, to finish; round up for the idle hold
  localparam int SETTLE_CYCLES = 64;
  // cycles with no handshake and no register write before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // least number of input items over the whole run
  localparam int ITEM_TARGET   = 500;
  localparam int ROW_SLOTS     = MAX_KERNEL_DEF + 1;
  // the kind code that the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ic2d_stream_if #(.data_t(in_item_t)) in_ch ();
  ic2d_stream_if #(.data_t(out_item_t)) out_ch ();

  image_convolution_2d dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // predictor state: own copy of registers, coefficients, rows and positions
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] kern_coef [0:48];
  logic [PIX_W-1:0] row_buf [0:ROW_SLOTS*MAX_WIDTH_DEF-1];
  int unsigned reg_width, reg_height, reg_kw, reg_kh;
  int unsigned src_col, src_row, dst_col, dst_row;
  bit frame_in;

  out_item_t conv_expected [$];
  int unsigned mismatches;
  bit idle_on;
  int unsigned sent_items;

  // geometry as the block applies it
  function automatic int unsigned act_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return reg_width;
  endfunction

  function automatic int unsigned act_height();
    if (reg_height == 0) return 1;
    if (reg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return reg_height;
  endfunction

  function automatic bit kernel_valid();
    return reg_kw[0] && reg_kh[0] && reg_kw <= MAX_KERNEL_DEF && reg_kh <= MAX_KERNEL_DEF;
  endfunction

  function automatic int clip_pos(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // one accepted item through the predictor
  task automatic conv_step(input in_item_t it, output bit got, output out_item_t res);
    int unsigned w, h, rw, rh, need_r, need_c;
    longint acc;
    int r, c;
    bit last;
    got = 1'b0;
    res = '0;
    w = act_width();
    h = act_height();
    if (it.kind == KIND_COEF) begin
      if (it.coef_index < 49) kern_coef[it.coef_index] = it.coef_value;
      return;
    end
    if (it.kind != KIND_PIXEL && it.kind != KIND_DRAIN) return;
    if (!kernel_valid()) return;
    if (it.kind == KIND_PIXEL && !frame_in) begin
      row_buf[(src_row % ROW_SLOTS) * MAX_WIDTH_DEF + src_col] = it.pixel_in;
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
        if (src_row >= h) begin
          src_row = 0;
          frame_in = 1'b1;
        end
      end
    end
    rw = reg_kw / 2;
    rh = reg_kh / 2;
    need_r = (dst_row + rh > h - 1) ? h - 1 : dst_row + rh;
    need_c = (dst_col + rw > w - 1) ? w - 1 : dst_col + rw;
    if (!(frame_in || src_row > need_r || (src_row == need_r && src_col > need_c))) return;
    acc = 0;
    for (int i = 0; i < reg_kh; i++) begin
      r = clip_pos(int'(dst_row) + i - int'(rh), int'(h) - 1);
      for (int j = 0; j < reg_kw; j++) begin
        c = clip_pos(int'(dst_col) + j - int'(rw), int'(w) - 1);
        acc += longint'(kern_coef[i * reg_kw + j]) *
               longint'(row_buf[(r % ROW_SLOTS) * MAX_WIDTH_DEF + c]);
      end
    end
    // floor of a positive Q12 sum, then clip
    if (acc <= 0) res.pixel_out = '0;
    else if ((acc >>> FRAC_W) > 255) res.pixel_out = 8'd255;
    else res.pixel_out = PIX_W'(acc >>> FRAC_W);
    last = (dst_row == h - 1) && (dst_col == w - 1);
    res.frame_last = last;
    got = 1'b1;
    if (last) begin
      dst_row = 0;
      dst_col = 0;
      frame_in = 1'b0;
    end else begin
      dst_col++;
      if (dst_col >= w) begin
        dst_col = 0;
        dst_row++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (conv_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected item pixel_out=%0d frame_last=%0d",
                                  out_ch.data.pixel_out, out_ch.data.frame_last));
      end else begin
        want = conv_expected.pop_front();
        if (out_ch.data.pixel_out !== want.pixel_out)
          report_mismatch($sformatf("pixel_out got %0d want %0d",
                                    out_ch.data.pixel_out, want.pixel_out));
        if (out_ch.data.frame_last !== want.frame_last)
          report_mismatch($sformatf("frame_last got %0d want %0d",
                                    out_ch.data.frame_last, want.frame_last));
      end
    end
  end

  // gap lengths: mostly short, now and then long
  function automatic int unsigned gap_len();
    if (!idle_on) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // output backpressure
  int unsigned sink_hold;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_hold = gap_len();
    end
  end

  // watchdog on handshakes and register writes
  int unsigned stall_cycles;
  always @(posedge clk) begin
    if (rst || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // presents one item, waits for the handshake, then runs the predictor;
  // typed expectations override the predicted one
  task automatic send_item(input in_item_t it, input bit typed, input bit want_any,
                           input out_item_t want);
    bit got;
    out_item_t res;
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent_items++;
    conv_step(it, got, res);
    if (typed) begin
      if (want_any) conv_expected.push_back(want);
    end else if (got) begin
      conv_expected.push_back(res);
    end
  endtask

  task automatic send(input in_item_t it);
    send_item(it, 1'b0, 1'b0, '0);
  endtask

  function automatic in_item_t make_item(logic [KIND_W-1:0] k, int unsigned pix,
                                         int unsigned idx, int val);
    in_item_t it;
    it.kind = k;
    it.pixel_in = PIX_W'(pix);
    it.coef_index = CIDX_W'(idx);
    it.coef_value = COEF_W'(val);
    return it;
  endfunction

  // lower valid, wait for every expected item, then let a last item finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (conv_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all four registers, one per cycle; any write restarts the frame
  task automatic configure(input int unsigned w, h, kw, kh);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;   cfg_data <= CFG_DATA_W'(w);  @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;  cfg_data <= CFG_DATA_W'(h);  @(posedge clk);
    cfg_index <= REG_KERNEL_WIDTH;  cfg_data <= CFG_DATA_W'(kw); @(posedge clk);
    cfg_index <= REG_KERNEL_HEIGHT; cfg_data <= CFG_DATA_W'(kh); @(posedge clk);
    cfg_we <= 1'b0;
    reg_width = w & 12'h7FF;
    reg_height = h & 13'h1FFF;
    reg_kw = kw & 7;
    reg_kh = kh & 7;
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    frame_in = 1'b0;
  endtask

  function automatic int coef_draw(int unsigned taps);
    int unsigned span;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    span = 12288 / ((taps == 0) ? 1 : taps);
    return int'($urandom_range(0, span)) - int'(span / 5);
  endfunction

  function automatic int unsigned pix_draw();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // a random stray item: drain, kind 3, or coefficient write (some out of range)
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0: send(make_item(KIND_SPARE, $urandom_range(0, 255), $urandom_range(0, 63),
                        int'($urandom_range(0, 65535))));
      1: send(make_item(KIND_COEF, 0, $urandom_range(49, 63),
                        int'($urandom_range(0, 65535))));
      2: send(make_item(KIND_COEF, 0, $urandom_range(0, reg_kw * reg_kh - 1),
                        coef_draw(reg_kw * reg_kh)));
      default: send(make_item(KIND_DRAIN, $urandom_range(0, 255), $urandom_range(0, 63),
                              int'($urandom_range(0, 65535))));
    endcase
  endtask

  // one frame with random content; an aborted frame stops after npix pixels
  task automatic run_frame(input int unsigned npix, input bit aborted);
    for (int unsigned k = 0; k < npix; k++) begin
      if ($urandom_range(0, 9) < 2) send_noise();
      send(make_item(KIND_PIXEL, pix_draw(), $urandom_range(0, 63),
                     int'($urandom_range(0, 65535))));
    end
    if (aborted) return;
    // flush what is still pending; pixels here arrive too early and only move outputs
    while (frame_in) begin
      if ($urandom_range(0, 4) == 0)
        send(make_item(KIND_PIXEL, pix_draw(), 0, 0));
      else
        send(make_item(KIND_DRAIN, pix_draw(), 0, 0));
    end
  endtask

  task automatic run_phase(input int unsigned w, h, kw, kh, npix, input bit aborted);
    int unsigned taps;
    settle();
    configure(w, h, kw, kh);
    idle_on = $urandom_range(0, 3) != 0;
    if (kernel_valid()) begin
      taps = reg_kw * reg_kh;
      for (int unsigned t = 0; t < taps; t++)
        send(make_item(KIND_COEF, 0, t, coef_draw(taps)));
    end
    run_frame(npix, aborted);
  endtask

  // directed rows with a 1x1 kernel on a 1x1 image: each pixel is its own frame
  typedef struct {
    in_item_t  it;
    bit        typed;
    bit        want_any;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed [19] = '{
    '{make_item(KIND_COEF,  0, 0, 4096),   1, 0, '0},
    '{make_item(KIND_PIXEL, 200, 0, 0),    1, 1, '{8'd200, 1'b1}},
    '{make_item(KIND_PIXEL, 0, 0, 0),      1, 1, '{8'd0, 1'b1}},
    '{make_item(KIND_PIXEL, 255, 0, 0),    1, 1, '{8'd255, 1'b1}},
    // largest weight saturates
    '{make_item(KIND_COEF,  0, 0, 32767),  1, 0, '0},
    '{make_item(KIND_PIXEL, 255, 0, 0),    1, 1, '{8'd255, 1'b1}},
    '{make_item(KIND_PIXEL, 1, 0, 0),      1, 1, '{8'd7, 1'b1}},
    // most negative weight clips to zero
    '{make_item(KIND_COEF,  0, 0, -32768), 1, 0, '0},
    '{make_item(KIND_PIXEL, 255, 0, 0),    1, 1, '{8'd0, 1'b1}},
    // index above 48 is dropped
    '{make_item(KIND_COEF,  0, 63, 4096),  1, 0, '0},
    '{make_item(KIND_PIXEL, 90, 0, 0),     1, 1, '{8'd0, 1'b1}},
    '{make_item(KIND_COEF,  0, 48, 12345), 1, 0, '0},
    // kind 3 and drain with nothing ready make no item
    '{make_item(KIND_SPARE, 255, 63, -1),  1, 0, '0},
    '{make_item(KIND_DRAIN, 255, 63, -1),  1, 0, '0},
    // sub-unit weight floors away
    '{make_item(KIND_COEF,  0, 0, 1),      1, 0, '0},
    '{make_item(KIND_PIXEL, 255, 0, 0),    1, 1, '{8'd0, 1'b1}},
    '{make_item(KIND_COEF,  0, 0, 6144),   1, 0, '0},
    '{make_item(KIND_PIXEL, 171, 0, 0),    0, 0, '0},
    '{make_item(KIND_PIXEL, 85, 0, 0),     0, 0, '0}
  };

  initial begin
    int unsigned w, h, kw, kh;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    mismatches = 0;
    sent_items = 0;
    idle_on = 1'b1;
    reg_width = 1024; reg_height = 1; reg_kw = 3; reg_kh = 3;
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    frame_in = 1'b0;
    foreach (kern_coef[t]) kern_coef[t] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every coefficient gets written before any pixel can read one
    for (int unsigned t = 0; t < 49; t++)
      send(make_item(KIND_COEF, 0, t, coef_draw(49)));
    settle();
    configure(1, 1, 1, 1);
    foreach (directed[n])
      send_item(directed[n].it, directed[n].typed, directed[n].want_any, directed[n].want);

    // register extremes: widest and tallest geometry, oversize and zero codes
    run_phase(1024, 1, 3, 3, 16, 1);
    run_phase(2047, 1, 7, 1, 16, 1);
    run_phase(1, 8191, 1, 7, 10, 1);
    run_phase(1, 4096, 1, 7, 12, 1);
    run_phase(0, 4, 3, 5, 4, 0);
    run_phase(5, 0, 5, 3, 5, 0);
    run_phase(7, 4, 7, 7, 28, 0);
    // even or zero kernel sizes ignore pixels and drains
    run_phase(4, 2, 2, 3, 8, 0);
    run_phase(4, 2, 3, 0, 8, 0);
    run_phase(4, 2, 6, 4, 8, 0);

    while (sent_items < ITEM_TARGET) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      kw = 2 * $urandom_range(0, 3) + 1;
      kh = 2 * $urandom_range(0, 3) + 1;
      if ($urandom_range(0, 11) == 0) kw = 2 * $urandom_range(0, 3);
      if ($urandom_range(0, 5) == 0)
        run_phase(w, h, kw, kh, $urandom_range(1, w * h), 1);
      else
        run_phase(w, h, kw, kh, w * h, 0);
    end

    settle();
    if (conv_expected.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived", conv_expected.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> image_convolution_2d.f
src/ic2d_pkg.sv
src/ic2d_stream_if.sv
src/ic2d_ram.sv
src/image_convolution_2d.sv
tb/sv/testbench.sv
